### hdl/intel_hex_record_loader_defines.svh
// Assertion macros for the Intel HEX record loader.
// Included by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef INTEL_HEX_RECORD_LOADER_DEFINES_SVH
`define INTEL_HEX_RECORD_LOADER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define IHEX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ihex assertion failed");
// Next-cycle implication.
`define IHEX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ihex assertion failed");
`else
`define IHEX_ASSERT_NOW(label, ante, cons)
`define IHEX_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/ihex_pkg.sv
// Shared types, codes and constants of the Intel HEX record loader.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int MAX_DATA_DEFAULT = 32;

    localparam int          ADDR_W          = 17;
    localparam logic [16:0] ADDR_MASK_RESET = 17'h0FFFF;
    localparam logic [9:0]  POS_LIMIT       = 10'd1023;
    localparam logic [9:0]  HDR_END         = 10'd11;
    localparam logic [8:0]  FIRST_DATA_PAIR = 9'd5;
    localparam logic [7:0]  CH_COLON        = 8'h3A;
    localparam logic [4:0]  HEX_INVALID     = 5'd16;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] REC_DATA = 8'd0;
    localparam logic [7:0] REC_EOF  = 8'd1;

    localparam logic [1:0] LS_BLANK    = 2'd0;
    localparam logic [1:0] LS_ACCEPTED = 2'd1;
    localparam logic [1:0] LS_BAD      = 2'd2;
    localparam logic [1:0] LS_REFUSED  = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [16:0] write_address;
        logic [7:0]  write_byte;
        logic        last;
        logic [1:0]  line_status;
        logic        more_wanted;
        logic [31:0] record_count;
        logic [31:0] byte_count;
        logic [31:0] bad_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_STATUS
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_char;
        logic eval_line;
        logic rd_buf;
        logic load_write;
        logic load_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_writes;
        logic last_write;
        logic out_free;
    } t_dp_stat;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = 5'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            v = 5'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            v = 5'(c - 8'h37);
        end else begin
            v = HEX_INVALID;
        end
        return v;
    endfunction

endpackage

### hdl/ihex_ctrl.sv
// Controller of the Intel HEX record loader: sequences line evaluation and the write drain.
// Depends on ihex_pkg; drives the datapath through t_dp_cmd.
`timescale 1ns / 1ps

module ihex_ctrl
    import ihex_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_op,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_CHAR) begin
                        o_cmd.take_char = 1'b1;
                    end else begin
                        o_cmd.eval_line = 1'b1;
                        n_state = i_stat.has_writes ? S_READ : S_STATUS;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_buf = 1'b1;
                n_state      = S_WRITE;
            end
            S_WRITE: begin
                // hold the byte until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.load_write = 1'b1;
                    n_state = i_stat.last_write ? S_STATUS : S_READ;
                end
            end
            S_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.load_status = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/ihex_datapath.sv
// Datapath of the Intel HEX record loader: character parser, data buffer, totals, output register.
// Depends on ihex_pkg and the assertion macros in intel_hex_record_loader_defines.svh.
`timescale 1ns / 1ps
`include "intel_hex_record_loader_defines.svh"

module ihex_datapath
    import ihex_pkg::*;
#(
    parameter int MAX_DATA = MAX_DATA_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    input  t_in_item    i_in,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    localparam int IW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

    logic [16:0] r_addr_mask;
    logic [9:0]  r_pos,      n_pos;
    logic        r_early,    n_early;
    logic        r_failed,   n_failed;
    logic [3:0]  r_hi_nib,   n_hi_nib;
    logic [7:0]  r_len,      n_len;
    logic [15:0] r_addr,     n_addr;
    logic [7:0]  r_type,     n_type;
    logic [7:0]  r_sum,      n_sum;
    logic        r_end_seen, n_end_seen;
    logic [31:0] r_records,  n_records;
    logic [31:0] r_bytes,    n_bytes;
    logic [31:0] r_bad,      n_bad;
    logic [1:0]  r_status,   n_status;
    logic [IW-1:0] r_idx,    n_idx;
    logic [7:0]  r_rd_data;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out,       n_out;

    logic [7:0]  r_buf [MAX_DATA];

    logic [9:0]  rec_end;
    logic [4:0]  digit;
    logic [7:0]  pair_byte;
    logic [8:0]  buf_k;
    logic        buf_we;
    logic [1:0]  line_class;
    logic        out_free;

    assign rec_end   = {1'b0, r_len, 1'b0} + HDR_END;
    assign digit     = hex_value(i_in.ch);
    assign pair_byte = {r_hi_nib, digit[3:0]};
    assign buf_k     = r_pos[9:1] - FIRST_DATA_PAIR;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_end_seen) begin
            line_class = LS_REFUSED;
        end else if (r_pos == '0) begin
            line_class = LS_BLANK;
        end else if (r_failed || (r_pos < rec_end) || (r_sum != '0)
                     || ((r_type == REC_DATA) && (r_len > 8'(MAX_DATA)))) begin
            line_class = LS_BAD;
        end else begin
            line_class = LS_ACCEPTED;
        end
    end

    assign o_stat.has_writes = (line_class == LS_ACCEPTED) && (r_type == REC_DATA)
                               && (r_len != '0);
    assign o_stat.last_write = ({{(8 - IW){1'b0}}, r_idx} + 8'd1) == r_len;
    assign o_stat.out_free   = out_free;

    always_comb begin
        n_pos      = r_pos;
        n_early    = r_early;
        n_failed   = r_failed;
        n_hi_nib   = r_hi_nib;
        n_len      = r_len;
        n_addr     = r_addr;
        n_type     = r_type;
        n_sum      = r_sum;
        n_end_seen = r_end_seen;
        n_records  = r_records;
        n_bytes    = r_bytes;
        n_bad      = r_bad;
        n_status   = r_status;
        n_idx      = r_idx;
        buf_we     = 1'b0;

        if (i_cmd.take_char) begin
            if (!r_end_seen && !r_early && (r_pos != POS_LIMIT)) begin
                if (i_in.ch == '0) begin
                    n_early = 1'b1;
                end else begin
                    n_pos = r_pos + 10'd1;
                    if (r_failed) begin
                        // drop the rest of a failed line
                    end else if (r_pos == '0) begin
                        n_failed = (i_in.ch != CH_COLON);
                    end else if (r_pos >= rec_end) begin
                        // past the checksum: ignore
                    end else if (digit == HEX_INVALID) begin
                        n_failed = 1'b1;
                    end else if (r_pos[0]) begin
                        n_hi_nib = digit[3:0];
                    end else begin
                        n_sum = r_sum + pair_byte;
                        case (r_pos)
                            10'd2:   n_len = pair_byte;
                            10'd4:   n_addr = {pair_byte, r_addr[7:0]};
                            10'd6:   n_addr = {r_addr[15:8], pair_byte};
                            10'd8:   n_type = pair_byte;
                            default: begin
                                buf_we = (buf_k < {1'b0, r_len}) && (buf_k < 9'(MAX_DATA));
                            end
                        endcase
                    end
                end
            end
        end

        if (i_cmd.eval_line) begin
            n_status = line_class;
            n_idx    = '0;
            if (line_class == LS_BAD) begin
                n_bad = r_bad + 32'd1;
            end else if (line_class == LS_ACCEPTED) begin
                n_records = r_records + 32'd1;
                if (r_type == REC_DATA) begin
                    n_bytes = r_bytes + 32'(r_len);
                end
                if (r_type == REC_EOF) begin
                    n_end_seen = 1'b1;
                end
            end
        end

        if (i_cmd.load_write) begin
            n_idx = r_idx + IW'(1);
        end

        // clear the line once its status has gone out
        if (i_cmd.load_status) begin
            n_pos    = '0;
            n_early  = 1'b0;
            n_failed = 1'b0;
            n_hi_nib = '0;
            n_len    = '0;
            n_addr   = '0;
            n_type   = '0;
            n_sum    = '0;
        end
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.load_write) begin
            n_out               = '0;
            n_out.kind          = KIND_WRITE;
            n_out.write_address = ({1'b0, r_addr} + 17'(r_idx)) & r_addr_mask;
            n_out.write_byte    = r_rd_data;
            n_out_valid         = 1'b1;
        end else if (i_cmd.load_status) begin
            n_out              = '0;
            n_out.kind         = KIND_STATUS;
            n_out.last         = 1'b1;
            n_out.line_status  = r_status;
            n_out.more_wanted  = !r_end_seen;
            n_out.record_count = r_records;
            n_out.byte_count   = r_bytes;
            n_out.bad_count    = r_bad;
            n_out_valid        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_mask <= ADDR_MASK_RESET;
            r_pos       <= '0;
            r_early     <= 1'b0;
            r_failed    <= 1'b0;
            r_hi_nib    <= '0;
            r_len       <= '0;
            r_addr      <= '0;
            r_type      <= '0;
            r_sum       <= '0;
            r_end_seen  <= 1'b0;
            r_records   <= '0;
            r_bytes     <= '0;
            r_bad       <= '0;
            r_status    <= LS_BLANK;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_addr_mask <= i_cfg_data;
            end
            r_pos       <= n_pos;
            r_early     <= n_early;
            r_failed    <= n_failed;
            r_hi_nib    <= n_hi_nib;
            r_len       <= n_len;
            r_addr      <= n_addr;
            r_type      <= n_type;
            r_sum       <= n_sum;
            r_end_seen  <= n_end_seen;
            r_records   <= n_records;
            r_bytes     <= n_bytes;
            r_bad       <= n_bad;
            r_status    <= n_status;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // data byte buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[buf_k[IW-1:0]] <= pair_byte;
        end
        if (i_cmd.rd_buf) begin
            r_rd_data <= r_buf[r_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `IHEX_ASSERT_NOW(a_load_when_free, i_cmd.load_write || i_cmd.load_status, out_free)
    `IHEX_ASSERT_NEXT(a_drain_starts_at_zero, i_cmd.eval_line, r_idx == '0)
    `IHEX_ASSERT_NEXT(a_early_end_holds_pos, r_early && i_cmd.take_char, $stable(r_pos))
    `IHEX_ASSERT_NEXT(a_end_seen_sticks, r_end_seen, r_end_seen)

endmodule

### hdl/intel_hex_record_loader.sv
// Intel HEX record loader: one character (or end-of-line mark) per input item; a line
// yields masked memory writes of its data bytes and then one status item. A character
// is taken whenever the block is idle. An end-of-line mark is evaluated, then each data
// byte is read from the byte buffer and then loaded into the output register, and last
// the status item is loaded; each load waits while o_out is stalled.
// Input is taken again as soon as the status item sits in the output register.
// The user writes address_mask through i_cfg_we / i_cfg_data only while the block is
// idle; the block does not enforce it. Depends on ihex_pkg, ihex_ctrl and ihex_datapath.
`timescale 1ns / 1ps

module intel_hex_record_loader
    import ihex_pkg::*;
#(
    parameter int MAX_DATA = MAX_DATA_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ihex_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in.op),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ihex_datapath #(
        .MAX_DATA (MAX_DATA)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
